### hdl/usb_host_controller_register_file_defines.svh
// ----------------------------------------------------------------------------
// USB host controller register file: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef USB_HOST_CONTROLLER_REGISTER_FILE_DEFINES_SVH
`define USB_HOST_CONTROLLER_REGISTER_FILE_DEFINES_SVH

// Checked only while out of reset.
`define UHCRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define UHCRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/uhcrf_pkg.sv
// ----------------------------------------------------------------------------
// USB host controller register file package
// Register map, capability constants and the shared register state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uhcrf_pkg;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } uhcrf_op_e;

  localparam int unsigned MaxSlots = 32;
  localparam int unsigned MaxPorts = 32;

  // Capability block
  localparam logic [15:0] AddrCapLength  = 16'h0000;
  localparam logic [15:0] AddrHcsParams1 = 16'h0004;
  localparam logic [15:0] AddrHccParams1 = 16'h0010;
  localparam logic [15:0] AddrDbOff      = 16'h0014;
  localparam logic [15:0] AddrRtsOff     = 16'h0018;

  // Operational block
  localparam logic [15:0] AddrUsbCmd   = 16'h0080;
  localparam logic [15:0] AddrUsbSts   = 16'h0084;
  localparam logic [15:0] AddrPageSize = 16'h0088;
  localparam logic [15:0] AddrDnCtrl   = 16'h0094;
  localparam logic [15:0] AddrCrcrLo   = 16'h0098;
  localparam logic [15:0] AddrCrcrHi   = 16'h009C;
  localparam logic [15:0] AddrDcbaaLo  = 16'h00B0;
  localparam logic [15:0] AddrDcbaaHi  = 16'h00B4;
  localparam logic [15:0] AddrConfig   = 16'h00B8;

  // Port status words
  localparam logic [15:0] PortBase      = 16'h0400;
  localparam logic [15:0] PortLast      = 16'h13FC;
  localparam logic [7:0]  ConnectedPort = 8'd16;
  localparam logic [31:0] PortscIdle    = 32'h0000_0202;
  localparam logic [31:0] PortscConn    = 32'h0000_0203;

  // Runtime block, interrupter 0
  localparam logic [15:0] RtBase       = 16'h2000;
  localparam logic [15:0] RtLast       = 16'h2FFC;
  localparam logic [15:0] AddrIman     = 16'h2020;
  localparam logic [15:0] AddrErstSz   = 16'h2028;
  localparam logic [15:0] AddrErstBaLo = 16'h2030;
  localparam logic [15:0] AddrErstBaHi = 16'h2034;
  localparam logic [15:0] AddrErdpLo   = 16'h2038;
  localparam logic [15:0] AddrErdpHi   = 16'h203C;

  localparam logic [15:0] AddrDoorbell0 = 16'h3000;

  // Fixed read values
  localparam logic [31:0] CapLengthVal  = 32'h0100_0080;
  localparam logic [31:0] HccParams1Val = 32'h2000_0001;
  localparam logic [31:0] DbOffVal      = 32'h0000_3000;
  localparam logic [31:0] RtsOffVal     = 32'h0000_2000;
  localparam logic [31:0] PageSizeVal   = 32'h0000_0001;

  // Extended capability list, starts at bit 15 of the offset
  localparam int unsigned ExtWords = 14;
  localparam logic [31:0] ExtTable [ExtWords] = '{
    32'h0200_0802, 32'h2042_5355, 32'h3000_1001, 32'h0000_0000,
    32'h000C_0021, 32'h05DC_0012, 32'h01E0_0023, 32'h0000_0000,
    32'h0300_0002, 32'h2042_5355, 32'h1000_1011, 32'h0000_0000,
    32'h0005_0134, 32'h0000_0000
  };

  typedef struct packed {
    logic [31:0] usb_command;
    logic [31:0] notify_control;
    logic [63:0] cmd_ring_control;
    logic [63:0] context_array_pointer;
    logic [31:0] slots_enabled;
    logic [31:0] intr_management;
    logic [31:0] event_table_size;
    logic [63:0] event_table_base;
    logic [63:0] event_dequeue_pointer;
  } uhcrf_regs_t;

endpackage

`default_nettype wire

### hdl/uhcrf_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one register access item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface uhcrf_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] offset;
  logic [31:0] write_data;

  modport source (output valid, output opcode, output offset, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input offset, input write_data,
                  output ready);
endinterface

`default_nettype wire

### hdl/uhcrf_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one access result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface uhcrf_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        command_kick;

  modport source (output valid, output read_data, output command_kick,
                  input ready);
  modport sink   (input valid, input read_data, input command_kick,
                  output ready);
endinterface

`default_nettype wire

### hdl/uhcrf_decode.sv
// ----------------------------------------------------------------------------
// Read decoder
// Maps an offset in the register window to the value a read returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uhcrf_decode (
  input  wire logic [15:0]           offset_i,
  input  wire uhcrf_pkg::uhcrf_regs_t regs_i,
  output logic [31:0]                read_data_o
);

  logic [15:0] off;
  logic [7:0]  port_idx;
  logic [12:0] ext_idx;
  logic [31:0] hcs_params1;

  assign off         = {offset_i[15:2], 2'b00};
  assign port_idx    = 8'(off[15:4] - 12'h040);
  assign ext_idx     = off[14:2];
  assign hcs_params1 = {8'(uhcrf_pkg::MaxPorts), 8'h00, 8'h01, 8'(uhcrf_pkg::MaxSlots)};

  always_comb begin
    read_data_o = '0;
    if (off inside {[uhcrf_pkg::RtBase:uhcrf_pkg::RtLast]}) begin
      case (off)
        uhcrf_pkg::AddrIman:     read_data_o = regs_i.intr_management;
        uhcrf_pkg::AddrErstSz:   read_data_o = regs_i.event_table_size;
        uhcrf_pkg::AddrErstBaLo: read_data_o = regs_i.event_table_base[31:0];
        uhcrf_pkg::AddrErstBaHi: read_data_o = regs_i.event_table_base[63:32];
        uhcrf_pkg::AddrErdpLo:   read_data_o = regs_i.event_dequeue_pointer[31:0];
        uhcrf_pkg::AddrErdpHi:   read_data_o = regs_i.event_dequeue_pointer[63:32];
        default:                 read_data_o = '0;
      endcase
    end else if (off inside {[uhcrf_pkg::PortBase:uhcrf_pkg::PortLast]}) begin
      // only word 0 of each port exists
      if ({1'b0, port_idx} < 9'(uhcrf_pkg::MaxPorts) && off[3:2] == 2'b00) begin
        read_data_o = (port_idx == uhcrf_pkg::ConnectedPort) ? uhcrf_pkg::PortscConn
                                                             : uhcrf_pkg::PortscIdle;
      end
    end else if (off[15]) begin
      if (ext_idx < 13'(uhcrf_pkg::ExtWords)) begin
        read_data_o = uhcrf_pkg::ExtTable[ext_idx[3:0]];
      end
    end else begin
      case (off)
        uhcrf_pkg::AddrCapLength:  read_data_o = uhcrf_pkg::CapLengthVal;
        uhcrf_pkg::AddrHcsParams1: read_data_o = hcs_params1;
        uhcrf_pkg::AddrHccParams1: read_data_o = uhcrf_pkg::HccParams1Val;
        uhcrf_pkg::AddrDbOff:      read_data_o = uhcrf_pkg::DbOffVal;
        uhcrf_pkg::AddrRtsOff:     read_data_o = uhcrf_pkg::RtsOffVal;
        uhcrf_pkg::AddrUsbCmd:     read_data_o = regs_i.usb_command;
        uhcrf_pkg::AddrUsbSts:     read_data_o = {31'd0, ~regs_i.usb_command[0]};
        uhcrf_pkg::AddrPageSize:   read_data_o = uhcrf_pkg::PageSizeVal;
        uhcrf_pkg::AddrDnCtrl:     read_data_o = regs_i.notify_control;
        uhcrf_pkg::AddrCrcrLo:     read_data_o = regs_i.cmd_ring_control[31:0];
        uhcrf_pkg::AddrCrcrHi:     read_data_o = regs_i.cmd_ring_control[63:32];
        uhcrf_pkg::AddrDcbaaLo:    read_data_o = regs_i.context_array_pointer[31:0];
        uhcrf_pkg::AddrDcbaaHi:    read_data_o = regs_i.context_array_pointer[63:32];
        uhcrf_pkg::AddrConfig:     read_data_o = regs_i.slots_enabled;
        default:                   read_data_o = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/usb_host_controller_register_file.sv
// ----------------------------------------------------------------------------
// USB host controller register file
// One 32-bit read or write per item over a 64 KiB register window.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  req_i   | in  | valid/ready  | opcode, offset, write_data
//  rsp_o   | out | valid/ready  | read_data, command_kick
//
//  An accepted item is held in the input register, then decode and the
//  register update happen in a single pass into the result register; one item
//  per cycle is sustained while the result is not stalled. Reset clears only
//  the valid flags and register state; no clearing pass is needed.
//  A stalled result holds the input register; req_i.ready drops only then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usb_host_controller_register_file (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  uhcrf_req_if.sink    req_i,
  uhcrf_rsp_if.source  rsp_o
);

  logic        in_valid_q, in_valid_d;
  logic        in_opcode_q;
  logic [15:0] in_offset_q;
  logic [31:0] in_wdata_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_rdata_q, out_rdata_d;
  logic        out_kick_q, out_kick_d;

  uhcrf_pkg::uhcrf_regs_t regs_q, regs_d;

  logic        accept;
  logic        advance;
  logic        is_write;
  logic [15:0] off;
  logic [31:0] dec_rdata;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;
  assign is_write    = (in_opcode_q == uhcrf_pkg::OpWrite);
  assign off         = {in_offset_q[15:2], 2'b00};

  uhcrf_decode u_decode (
    .offset_i    (in_offset_q),
    .regs_i      (regs_q),
    .read_data_o (dec_rdata)
  );

  always_comb begin
    regs_d     = regs_q;
    out_kick_d = 1'b0;
    if (is_write) begin
      case (off)
        uhcrf_pkg::AddrDoorbell0: out_kick_d = 1'b1;
        uhcrf_pkg::AddrUsbCmd: begin
          regs_d.usb_command = in_wdata_q & ~32'h0000_0002;
          // host controller reset: self-clearing bit, wipes ring and interrupter
          if (in_wdata_q[1]) begin
            regs_d.cmd_ring_control      = '0;
            regs_d.intr_management       = '0;
            regs_d.event_table_size      = '0;
            regs_d.event_table_base      = '0;
            regs_d.event_dequeue_pointer = '0;
          end
        end
        uhcrf_pkg::AddrDnCtrl:   regs_d.notify_control = in_wdata_q;
        uhcrf_pkg::AddrCrcrLo:   regs_d.cmd_ring_control[31:0] = in_wdata_q;
        uhcrf_pkg::AddrCrcrHi:   regs_d.cmd_ring_control[63:32] = in_wdata_q;
        uhcrf_pkg::AddrDcbaaLo:  regs_d.context_array_pointer[31:0] = in_wdata_q;
        uhcrf_pkg::AddrDcbaaHi:  regs_d.context_array_pointer[63:32] = in_wdata_q;
        uhcrf_pkg::AddrConfig: begin
          regs_d.slots_enabled = (in_wdata_q > 32'(uhcrf_pkg::MaxSlots))
                                 ? 32'(uhcrf_pkg::MaxSlots) : in_wdata_q;
        end
        uhcrf_pkg::AddrIman:     regs_d.intr_management = in_wdata_q;
        uhcrf_pkg::AddrErstSz:   regs_d.event_table_size = in_wdata_q;
        uhcrf_pkg::AddrErstBaLo: regs_d.event_table_base[31:0] = in_wdata_q;
        uhcrf_pkg::AddrErstBaHi: regs_d.event_table_base[63:32] = in_wdata_q;
        uhcrf_pkg::AddrErdpLo:   regs_d.event_dequeue_pointer[31:0] = in_wdata_q;
        uhcrf_pkg::AddrErdpHi:   regs_d.event_dequeue_pointer[63:32] = in_wdata_q;
        default: ;
      endcase
    end
    out_rdata_d = is_write ? 32'd0 : dec_rdata;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        regs_q <= regs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_opcode_q <= req_i.opcode;
      in_offset_q <= req_i.offset;
      in_wdata_q  <= req_i.write_data;
    end
    if (advance) begin
      out_rdata_q <= out_rdata_d;
      out_kick_q  <= out_kick_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_data    = out_rdata_q;
  assign rsp_o.command_kick = out_kick_q;

endmodule

`default_nettype wire

### hdl/uhcrf_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the result channel of the register file over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "usb_host_controller_register_file_defines.svh"

module uhcrf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [31:0] rsp_read_data_i,
  input wire logic        rsp_command_kick_i
);

  `UHCRF_ASSERT(a_rsp_valid_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result dropped while stalled")
  `UHCRF_ASSERT(a_rsp_data_hold, rsp_valid_i && !rsp_ready_i |=> $stable(rsp_read_data_i) && $stable(rsp_command_kick_i), "stalled result changed")
  `UHCRF_ASSERT(a_kick_is_write, rsp_valid_i && rsp_command_kick_i |-> rsp_read_data_i == 32'd0, "doorbell kick carries read data")
  `UHCRF_ASSERT_ALWAYS(a_no_result_after_reset, !rst_ni |=> !rsp_valid_i, "result shown right after reset")

endmodule

bind usb_host_controller_register_file uhcrf_checker u_uhcrf_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_read_data_i    (rsp_o.read_data),
  .rsp_command_kick_i (rsp_o.command_kick)
);

`default_nettype wire
